// ===== design/max_sum_subrectangle_top_assert.svh =====
// ----------------------------------------------------------------------------
// max_sum_subrectangle_top_assert.svh
// Assertion macros shared by the maximum-sum sub-rectangle design.
// ----------------------------------------------------------------------------
`ifndef MAX_SUM_SUBRECTANGLE_TOP_ASSERT_SVH
`define MAX_SUM_SUBRECTANGLE_TOP_ASSERT_SVH

// same-cycle implication
`define MSR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg
// Types and constants of the maximum-sum sub-rectangle search.
// ----------------------------------------------------------------------------
`default_nettype none

package msr_pkg;

  localparam int unsigned CELL_W   = 32;
  localparam int unsigned SUM_W    = 44;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned IN_TD_W  = 32;
  localparam int unsigned OUT_TD_W = 72;

  localparam logic signed [SUM_W-1:0] BEST_INIT = {{(SUM_W-31){1'b1}}, 31'b0};

  // register index (paddr bit 2)
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_CMP,
    ST_DONE
  } msr_state_e;

endpackage

`default_nettype wire

// ===== design/max_sum_subrectangle_top.sv =====
// ----------------------------------------------------------------------------
// max_sum_subrectangle_top
// Loads a signed grid row-major, then runs a 2-D Kadane search over all
// column pairs and returns the best sub-rectangle sum and its bounds.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake               | payload
//  s_axis   | in  | tvalid/tready           | tdata[31:0] cell_value
//  m_axis   | out | tvalid/tready           | tdata: sum, top, bottom, left, right
//           |     |                         | tuser: found
//  apb      | in  | psel/penable/pready     | row_count @0x0, col_count @0x4
//
//  Load: one cell per cycle into the cell memory; tready is low during search.
//  Search: per column pair, the row reads go through the single read
//  port of the cell and row-sum memories, the row pipeline drains, then one
//  compare; C*(C+1)/2 pairs, then the result is handed off.
//  Reset: no clearing pass; row sums read as zero on the first column of a pass.
//  Result stalls hold only the hand-off; the next grid may load meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module max_sum_subrectangle_top #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // cell_value[31:0]
  input  wire  [msr_pkg::IN_TD_W-1:0]  s_axis_tdata_i,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // best_sum[43:0], top_row[49:44], bottom_row[55:50], left_col[61:56],
  // right_col[67:62], zero[71:68]
  output logic [msr_pkg::OUT_TD_W-1:0] m_axis_tdata_o,
  // found[0]
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  input  wire                          psel_i,
  input  wire                          penable_i,
  input  wire                          pwrite_i,
  input  wire  [msr_pkg::APB_AW-1:0]   paddr_i,
  input  wire  [msr_pkg::APB_DW-1:0]   pwdata_i,
  output logic [msr_pkg::APB_DW-1:0]   prdata_o,
  output logic                         pready_o
);
  import msr_pkg::*;

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RCW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW   = $clog2(MAX_COLS + 1);

  msr_state_e state_q, state_d;

  // configuration
  logic [RCW-1:0] rows_q;
  logic [CCW-1:0] cols_q;
  logic           cfg_wr;
  logic [CNT_W-1:0] wr_val;
  logic [RCW-1:0] rows_wr;
  logic [CCW-1:0] cols_wr;

  // load counters
  logic [CIW-1:0] lcol_q;
  logic [RIW-1:0] lrow_q;
  logic [AW-1:0]  laddr_q;
  logic           load_acc, load_last;

  // search sequencing
  logic [CIW-1:0] left_q, right_q;
  logic [RIW-1:0] row_q;
  logic [AW-1:0]  addr_q;
  logic           issue, cmp, hand_off;
  logic           row_end, right_end, left_end;

  // memories
  logic signed [CELL_W-1:0] cell_mem [CELLS];
  logic signed [SUM_W-1:0]  rs_mem [MAX_ROWS];
  logic signed [CELL_W-1:0] cell_rd_q;
  logic signed [SUM_W-1:0]  rs_rd_q;

  // pipeline
  logic           p1_vld_q, p2_vld_q, p1_fresh_q;
  logic [RIW-1:0] p1_row_q, p2_row_q;
  logic signed [SUM_W-1:0] ns, ns_q, run_sum;

  // Kadane / fallback state
  logic signed [SUM_W-1:0] run_q, peak_q, mx_q;
  logic [RIW-1:0] start_q, first_q, last_q, mxi_q;
  logic           hit_q;

  // best so far
  logic signed [SUM_W-1:0] best_q, cand;
  logic [RIW-1:0] btop_q, bbot_q, cfirst, clast;
  logic [CIW-1:0] bleft_q, bright_q;

  // result register
  logic signed [SUM_W-1:0] o_sum_q;
  logic [IDX_W-1:0] o_top_q, o_bot_q, o_left_q, o_right_q;
  logic             o_found_q, m_valid_q;

  // ---------------- configuration port ----------------
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;
  assign wr_val   = pwdata_i[CNT_W-1:0];

  always_comb begin
    if (wr_val == '0) begin
      rows_wr = RCW'(1);
      cols_wr = CCW'(1);
    end else begin
      rows_wr = (32'(wr_val) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(wr_val);
      cols_wr = (32'(wr_val) > 32'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(wr_val);
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      REG_ROW_COUNT: prdata_o = APB_DW'(rows_q);
      REG_COL_COUNT: prdata_o = APB_DW'(cols_q);
      default:       prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RCW'(MAX_ROWS > 64 ? 64 : MAX_ROWS);
      cols_q <= CCW'(MAX_COLS > 64 ? 64 : MAX_COLS);
    end else if (cfg_wr) begin
      unique case (paddr_i[2])
        REG_ROW_COUNT: rows_q <= rows_wr;
        REG_COL_COUNT: cols_q <= cols_wr;
        default: ;
      endcase
    end
  end

  // ---------------- control ----------------
  assign load_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign load_last = (CCW'(lcol_q) == cols_q - CCW'(1)) &&
                     (RCW'(lrow_q) == rows_q - RCW'(1));
  assign row_end   = RCW'(row_q) == rows_q - RCW'(1);
  assign right_end = CCW'(right_q) == cols_q - CCW'(1);
  assign left_end  = CCW'(left_q) == cols_q - CCW'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (load_acc && load_last) state_d = ST_SCAN;
      ST_SCAN:  if (row_end) state_d = ST_DRAIN;
      ST_DRAIN: if (!p1_vld_q && !p2_vld_q) state_d = ST_CMP;
      ST_CMP:   state_d = (right_end && left_end) ? ST_DONE : ST_SCAN;
      ST_DONE:  if (!m_valid_q || m_axis_tready_i) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    issue           = 1'b0;
    cmp             = 1'b0;
    hand_off        = 1'b0;
    unique case (state_q)
      ST_LOAD:  s_axis_tready_o = 1'b1;
      ST_SCAN:  issue = 1'b1;
      ST_CMP:   cmp = 1'b1;
      ST_DONE:  hand_off = !m_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else         state_q <= state_d;
  end

  // load counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcol_q  <= '0;
      lrow_q  <= '0;
      laddr_q <= '0;
    end else if (cfg_wr || (load_acc && load_last)) begin
      lcol_q  <= '0;
      lrow_q  <= '0;
      laddr_q <= '0;
    end else if (load_acc) begin
      laddr_q <= laddr_q + AW'(1);
      if (CCW'(lcol_q) == cols_q - CCW'(1)) begin
        lcol_q <= '0;
        lrow_q <= lrow_q + RIW'(1);
      end else begin
        lcol_q <= lcol_q + CIW'(1);
      end
    end
  end

  // column pair and row sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      row_q   <= '0;
      addr_q  <= '0;
    end else if (load_acc && load_last) begin
      left_q  <= '0;
      right_q <= '0;
      row_q   <= '0;
      addr_q  <= '0;
    end else if (issue) begin
      row_q  <= row_q + RIW'(1);
      addr_q <= addr_q + AW'(cols_q);
    end else if (cmp) begin
      row_q <= '0;
      if (!right_end) begin
        right_q <= right_q + CIW'(1);
        addr_q  <= AW'(right_q + CIW'(1));
      end else begin
        left_q  <= left_q + CIW'(1);
        right_q <= left_q + CIW'(1);
        addr_q  <= AW'(left_q + CIW'(1));
      end
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk_i) begin
    if (load_acc) cell_mem[laddr_q] <= s_axis_tdata_i[CELL_W-1:0];
    if (issue)    cell_rd_q <= cell_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (p1_vld_q) rs_mem[p1_row_q] <= ns;
    if (issue)    rs_rd_q <= rs_mem[row_q];
  end

  // ---------------- pipeline ----------------
  assign ns = (p1_fresh_q ? '0 : rs_rd_q) +
              {{(SUM_W-CELL_W){cell_rd_q[CELL_W-1]}}, cell_rd_q};
  assign run_sum = run_q + ns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= issue;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p1_row_q   <= row_q;
      p1_fresh_q <= right_q == left_q;
    end
    if (p1_vld_q) begin
      p2_row_q <= p1_row_q;
      ns_q     <= ns;
    end
  end

  // Kadane scan and fallback maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      run_q   <= '0;
      peak_q  <= BEST_INIT;
      start_q <= '0;
    end else if (cmp || (load_acc && load_last)) begin
      hit_q   <= 1'b0;
      run_q   <= '0;
      peak_q  <= BEST_INIT;
      start_q <= '0;
    end else if (p2_vld_q) begin
      if (run_sum[SUM_W-1]) begin
        run_q   <= '0;
        start_q <= p2_row_q + RIW'(1);
      end else begin
        run_q <= run_sum;
        if (run_sum > peak_q) begin
          peak_q <= run_sum;
          hit_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_vld_q) begin
      if (!run_sum[SUM_W-1] && run_sum > peak_q) begin
        first_q <= start_q;
        last_q  <= p2_row_q;
      end
      if (p2_row_q == '0 || ns_q > mx_q) begin
        mx_q  <= ns_q;
        mxi_q <= p2_row_q;
      end
    end
  end

  // ---------------- best tracking ----------------
  assign cand   = hit_q ? peak_q  : mx_q;
  assign cfirst = hit_q ? first_q : mxi_q;
  assign clast  = hit_q ? last_q  : mxi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q   <= BEST_INIT;
      btop_q   <= '0;
      bbot_q   <= '0;
      bleft_q  <= '0;
      bright_q <= '0;
    end else if (load_acc && load_last) begin
      best_q   <= BEST_INIT;
      btop_q   <= '0;
      bbot_q   <= '0;
      bleft_q  <= '0;
      bright_q <= '0;
    end else if (cmp && cand > best_q) begin
      best_q   <= cand;
      btop_q   <= cfirst;
      bbot_q   <= clast;
      bleft_q  <= left_q;
      bright_q <= right_q;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (hand_off) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hand_off) begin
      o_sum_q   <= best_q;
      o_top_q   <= IDX_W'(btop_q);
      o_bot_q   <= IDX_W'(bbot_q);
      o_left_q  <= IDX_W'(bleft_q);
      o_right_q <= IDX_W'(bright_q);
      o_found_q <= best_q > BEST_INIT;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = o_found_q;
  assign m_axis_tdata_o  = {4'b0, o_right_q, o_left_q, o_bot_q, o_top_q, o_sum_q};

  // ---------------- assertions ----------------
`include "max_sum_subrectangle_top_assert.svh"

  `MSR_ASSERT_IMP(a_load_pipe_idle, clk_i, rst_ni, s_axis_tready_o, !p1_vld_q && !p2_vld_q, "row pipeline busy while loading")
  `MSR_ASSERT_IMP(a_cmp_pipe_idle, clk_i, rst_ni, cmp, !p1_vld_q && !p2_vld_q, "compare before row pipeline drained")
  `MSR_ASSERT_IMP(a_hit_nonneg, clk_i, rst_ni, hit_q, !peak_q[SUM_W-1], "Kadane peak negative after a hit")
  `MSR_ASSERT_NXT(a_result_found, clk_i, rst_ni, hand_off, m_valid_q && (o_found_q == (o_sum_q > BEST_INIT)), "found flag disagrees with result sum")

endmodule

`default_nettype wire

// ===== tb/tb_max_sum_subrectangle_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_sum_subrectangle_top
// Streams grids of signed cells into the maximum-sum sub-rectangle search
// and checks each returned sum and its bounds against a 2-D Kadane predictor
// kept in a scoreboard. Grid sizes are set over APB between grids. Both
// stream sides idle at random, and the result side is held off once long
// enough to back up the loader.
// ----------------------------------------------------------------------------
module tb_max_sum_subrectangle_top;

  localparam int unsigned  DIM_MAX        = 64;
  localparam longint       SUM_FLOOR      = -64'sd2147483648;
  localparam logic [31:0]  CELL_MIN       = 32'h8000_0000;
  localparam logic [31:0]  CELL_MAX       = 32'h7fff_ffff;
  localparam int unsigned  HOLD_CYCLES    = 600;
  localparam int unsigned  SETTLE_CYCLES  = 8;
  localparam int unsigned  WATCHDOG_LIMIT = 60000;
  localparam int unsigned  CELL_TARGET    = 650;
  localparam int unsigned  GRID_TARGET    = 40;

  typedef struct {
    logic signed [msr_pkg::SUM_W-1:0] best_sum;
    logic [msr_pkg::IDX_W-1:0]        top_row;
    logic [msr_pkg::IDX_W-1:0]        bottom_row;
    logic [msr_pkg::IDX_W-1:0]        left_col;
    logic [msr_pkg::IDX_W-1:0]        right_col;
    logic                             found;
  } rect_t;

  class rect_scoreboard;
    int unsigned n_rows;
    int unsigned n_cols;
    int unsigned n_loaded;
    int          cells [DIM_MAX*DIM_MAX];
    rect_t       best_rect_q [$];
    int unsigned mismatches;

    function new();
      n_rows     = DIM_MAX;
      n_cols     = DIM_MAX;
      n_loaded   = 0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(logic [6:0] raw);
      if (raw == 0) return 1;
      if (raw > DIM_MAX) return DIM_MAX;
      return raw;
    endfunction

    function void write_dim(logic idx, logic [31:0] value);
      if (idx == msr_pkg::REG_ROW_COUNT) n_rows = clamp_dim(value[6:0]);
      else n_cols = clamp_dim(value[6:0]);
      n_loaded = 0;
    endfunction

    function int unsigned grid_size();
      return n_rows * n_cols;
    endfunction

    function int unsigned pending();
      return best_rect_q.size();
    endfunction

    // 2-D Kadane over all column pairs, strict improvement only
    function rect_t find_max_rect();
      longint      sums [DIM_MAX];
      longint      best, run, peak;
      int unsigned lc, rc, i, run_start, first, last;
      bit          hit;
      rect_t       r;
      best  = SUM_FLOOR;
      first = 0;
      last  = 0;
      r.top_row    = '0;
      r.bottom_row = '0;
      r.left_col   = '0;
      r.right_col  = '0;
      for (lc = 0; lc < n_cols; lc++) begin
        for (i = 0; i < DIM_MAX; i++) sums[i] = 0;
        for (rc = lc; rc < n_cols; rc++) begin
          for (i = 0; i < n_rows; i++) sums[i] += cells[i*n_cols + rc];
          run       = 0;
          peak      = SUM_FLOOR;
          run_start = 0;
          hit       = 1'b0;
          for (i = 0; i < n_rows; i++) begin
            run += sums[i];
            if (run < 0) begin
              run       = 0;
              run_start = i + 1;
            end else if (run > peak) begin
              peak  = run;
              first = run_start;
              last  = i;
              hit   = 1'b1;
            end
          end
          // all row sums negative: take the single largest, first on ties
          if (!hit) begin
            peak  = sums[0];
            first = 0;
            last  = 0;
            for (i = 1; i < n_rows; i++) begin
              if (sums[i] > peak) begin
                peak  = sums[i];
                first = i;
                last  = i;
              end
            end
          end
          if (peak > best) begin
            best         = peak;
            r.top_row    = first[5:0];
            r.bottom_row = last[5:0];
            r.left_col   = lc[5:0];
            r.right_col  = rc[5:0];
          end
        end
      end
      r.best_sum = best[msr_pkg::SUM_W-1:0];
      r.found    = (best > SUM_FLOOR);
      return r;
    endfunction

    function void note_cell(logic [31:0] value);
      if (n_loaded >= grid_size()) n_loaded = 0;
      cells[n_loaded] = value;
      n_loaded++;
      if (n_loaded == grid_size()) begin
        n_loaded = 0;
        best_rect_q = {best_rect_q, find_max_rect()};
      end
    endfunction

    function void check_result(logic [msr_pkg::OUT_TD_W-1:0] tdata, logic tuser);
      rect_t got;
      rect_t want;
      got.best_sum   = tdata[43:0];
      got.top_row    = tdata[49:44];
      got.bottom_row = tdata[55:50];
      got.left_col   = tdata[61:56];
      got.right_col  = tdata[67:62];
      got.found      = tuser;
      if (best_rect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result sum %0d found %0b", $realtime, got.best_sum,
                   got.found);
        return;
      end
      want = best_rect_q.pop_front();
      if (got.best_sum !== want.best_sum || got.top_row !== want.top_row ||
          got.bottom_row !== want.bottom_row || got.left_col !== want.left_col ||
          got.right_col !== want.right_col || got.found !== want.found) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: mismatch exp sum %0d rows %0d..%0d cols %0d..%0d found %0b",
                 $realtime, want.best_sum, want.top_row, want.bottom_row,
                 want.left_col, want.right_col, want.found);
          $display(" / got sum %0d rows %0d..%0d cols %0d..%0d found %0b",
                   got.best_sum, got.top_row, got.bottom_row, got.left_col,
                   got.right_col, got.found);
        end
      end
    endfunction
  endclass

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic [msr_pkg::IN_TD_W-1:0]   cell_tdata  = '0;
  logic                          cell_tvalid = 1'b0;
  logic                          cell_tready;
  logic [msr_pkg::OUT_TD_W-1:0]  res_tdata;
  logic                          res_tuser;
  logic                          res_tvalid;
  logic                          res_tready  = 1'b0;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [msr_pkg::APB_AW-1:0]    paddr       = '0;
  logic [msr_pkg::APB_DW-1:0]    pwdata      = '0;
  logic [msr_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  rect_scoreboard sb;
  bit             quiet    = 1'b0;
  bit             src_gaps = 1'b1;
  bit             hold_req = 1'b0;
  int unsigned    cells_sent   = 0;
  int unsigned    grids_done   = 0;
  int unsigned    stall_cycles = 0;

  max_sum_subrectangle_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (cell_tdata),
    .s_axis_tvalid_i (cell_tvalid),
    .s_axis_tready_o (cell_tready),
    .m_axis_tdata_o  (res_tdata),
    .m_axis_tuser_o  (res_tuser),
    .m_axis_tvalid_o (res_tvalid),
    .m_axis_tready_i (res_tready),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && res_tvalid && res_tready) sb.check_result(res_tdata, res_tuser);
  end

  always @(posedge clk) begin
    if ((cell_tvalid && cell_tready) || (res_tvalid && res_tready) || psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        res_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end else begin
        res_tready <= 1'b1;
        repeat ($urandom_range(0, 19)) @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_cell(int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return 32'($urandom_range(0, 40)) - 32'd20;
      2: return -32'($urandom_range(1, 5000));
      3: begin
        case ($urandom_range(0, 3))
          0: return CELL_MIN;
          1: return CELL_MAX;
          2: return CELL_MAX - 32'($urandom_range(0, 1000));
          default: return CELL_MIN + 32'($urandom_range(0, 1000));
        endcase
      end
      default: return CELL_MIN;
    endcase
  endfunction

  task automatic send_cell(input logic [31:0] value);
    if (src_gaps && !quiet && $urandom_range(0, 5) == 0) begin
      cell_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    cell_tdata  <= value;
    cell_tvalid <= 1'b1;
    do @(posedge clk); while (!cell_tready);
    sb.note_cell(value);
    cells_sent++;
  endtask

  task automatic drain_results();
    cell_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [6:0] count);
    logic [31:0] value;
    value   = {25'($urandom()), count};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_dim(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [6:0] rows, input logic [6:0] cols);
    drain_results();
    apb_write(msr_pkg::REG_ROW_COUNT, rows);
    apb_write(msr_pkg::REG_COL_COUNT, cols);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned size;
    int unsigned n_grids;
    int unsigned mode;
    int unsigned pick;
    int unsigned g;
    int unsigned k;
    logic [6:0]  rows;
    logic [6:0]  cols;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single cells; zero in both registers means one
    set_grid(7'd0, 7'd0);
    send_cell(CELL_MIN);
    send_cell(CELL_MIN + 32'd1);
    send_cell(CELL_MAX);
    send_cell(32'd0);
    send_cell(32'hffff_ffff);

    // all negative: falls back to the largest single row sum
    set_grid(7'd2, 7'd3);
    send_cell(-32'd5);
    send_cell(-32'd1);
    send_cell(-32'd7);
    send_cell(-32'd3);
    send_cell(-32'd9);
    send_cell(-32'd2);

    // register write mid-load restarts the grid; then all-zero ties
    set_grid(7'd2, 7'd2);
    send_cell(32'd5);
    send_cell(-32'd2);
    send_cell(32'd7);
    drain_results();
    apb_write(msr_pkg::REG_COL_COUNT, 7'd2);
    repeat (4) send_cell(32'd0);

    // full-scale cells in a single row
    set_grid(7'd1, 7'd3);
    send_cell(CELL_MAX);
    send_cell(CELL_MIN);
    send_cell(CELL_MAX);
    grids_done = 10;

    phase = 0;
    while (cells_sent < CELL_TARGET || grids_done < GRID_TARGET) begin
      drain_results();
      src_gaps = ($urandom_range(0, 1) == 1);
      n_grids  = $urandom_range(1, 4);
      if (phase == 0) begin
        set_grid(7'd127, 7'd1);
      end else if (phase == 1) begin
        set_grid(7'd1, 7'd64);
      end else if (phase == 2) begin
        hold_req = 1'b1;
        src_gaps = 1'b0;
        n_grids  = 8;
        set_grid(7'd2, 7'd2);
      end else begin
        pick = $urandom_range(0, 19);
        rows = 7'($urandom_range(1, 6));
        cols = 7'($urandom_range(1, 6));
        case (pick)
          0: rows = 7'd0;
          1: cols = 7'd0;
          2: begin
            rows = 7'($urandom_range(64, 127));
            cols = 7'($urandom_range(0, 1));
          end
          3: begin
            rows = 7'($urandom_range(0, 1));
            cols = 7'($urandom_range(64, 127));
          end
          default: ;
        endcase
        set_grid(rows, cols);
      end
      size = sb.grid_size();
      if (size > 16 && phase != 2) n_grids = 1;
      for (g = 0; g < n_grids; g++) begin
        pick = $urandom_range(0, 19);
        if (pick < 5) mode = 0;
        else if (pick < 11) mode = 1;
        else if (pick < 15) mode = 2;
        else if (pick < 19) mode = 3;
        else mode = 4;
        for (k = 0; k < size; k++) send_cell(pick_cell(mode));
        grids_done++;
      end
      // broken grid, abandoned by the next register write
      if (phase != 2 && size > 1 && $urandom_range(0, 7) == 0) begin
        n_grids = $urandom_range(1, size - 1);
        for (k = 0; k < n_grids; k++) send_cell($urandom());
      end
      if (cells_sent > CELL_TARGET - 90) quiet = 1'b1;
      phase++;
    end
    drain_results();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
